### rtl/core/flat_json_object_tokenizer_unit_defines.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef FLAT_JSON_OBJECT_TOKENIZER_UNIT_DEFINES_SVH
`define FLAT_JSON_OBJECT_TOKENIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge out of reset.
`define FJT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define FJT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FJT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FJT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/fjt_pkg.sv
// Types, codes and character constants for the flat object tokenizer.
`timescale 1ns / 1ps

package fjt_pkg;

  localparam int PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_WAIT_OPEN   = 4'd0;
  localparam logic [PhaseW-1:0] PH_FIRST_KEY   = 4'd1;
  localparam logic [PhaseW-1:0] PH_IN_KEY      = 4'd2;
  localparam logic [PhaseW-1:0] PH_AFTER_KEY   = 4'd3;
  localparam logic [PhaseW-1:0] PH_BEFORE_VAL  = 4'd4;
  localparam logic [PhaseW-1:0] PH_IN_VAL      = 4'd5;
  localparam logic [PhaseW-1:0] PH_AFTER_VAL   = 4'd6;
  localparam logic [PhaseW-1:0] PH_AFTER_VALWS = 4'd7;
  localparam logic [PhaseW-1:0] PH_NEXT_KEY    = 4'd8;

  localparam logic [2:0] K_NONE    = 3'd0;
  localparam logic [2:0] K_KEYBYTE = 3'd1;
  localparam logic [2:0] K_KEYEND  = 3'd2;
  localparam logic [2:0] K_VALBYTE = 3'd3;
  localparam logic [2:0] K_PAIREND = 3'd4;
  localparam logic [2:0] K_OBJEND  = 3'd5;
  localparam logic [2:0] K_ERROR   = 3'd6;

  localparam logic [2:0] E_NONE           = 3'd0;
  localparam logic [2:0] E_NO_BRACE       = 3'd1;
  localparam logic [2:0] E_NO_KEY_QUOTE   = 3'd2;
  localparam logic [2:0] E_OPEN_KEY       = 3'd3;
  localparam logic [2:0] E_NO_COLON       = 3'd4;
  localparam logic [2:0] E_NO_VALUE_QUOTE = 3'd5;
  localparam logic [2:0] E_OPEN_VALUE     = 3'd6;
  localparam logic [2:0] E_NO_COMMA       = 3'd7;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;

  typedef logic [PhaseW-1:0] phase_t;

  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] token_byte;
    logic [2:0] error_code;
  } result_t;

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

endpackage

### rtl/core/fjt_step.sv
// Next-phase and result logic for one text byte.
`timescale 1ns / 1ps

module fjt_step (
  input  fjt_pkg::phase_t  phase_i,
  input  logic [7:0]       text_byte_i,
  input  logic             end_of_text_i,
  output fjt_pkg::phase_t  phase_nxt_o,
  output fjt_pkg::result_t result_o
);

  fjt_pkg::phase_t nx;
  fjt_pkg::phase_t nx_final;
  logic [2:0]      kind;
  logic [7:0]      tbyte;
  logic [2:0]      err;
  logic            blank;

  function automatic logic [2:0] end_error(input fjt_pkg::phase_t ph);
    case (ph) inside
      fjt_pkg::PH_FIRST_KEY, fjt_pkg::PH_NEXT_KEY:   end_error = fjt_pkg::E_NO_KEY_QUOTE;
      fjt_pkg::PH_IN_KEY:                            end_error = fjt_pkg::E_OPEN_KEY;
      fjt_pkg::PH_AFTER_KEY:                         end_error = fjt_pkg::E_NO_COLON;
      fjt_pkg::PH_BEFORE_VAL:                        end_error = fjt_pkg::E_NO_VALUE_QUOTE;
      fjt_pkg::PH_IN_VAL:                            end_error = fjt_pkg::E_OPEN_VALUE;
      fjt_pkg::PH_AFTER_VAL, fjt_pkg::PH_AFTER_VALWS: end_error = fjt_pkg::E_NO_COMMA;
      default:                                       end_error = fjt_pkg::E_NO_BRACE;
    endcase
  endfunction

  assign blank = fjt_pkg::is_blank(text_byte_i);

  always_comb begin
    nx    = phase_i;
    kind  = fjt_pkg::K_NONE;
    tbyte = 8'd0;
    err   = fjt_pkg::E_NONE;
    unique case (phase_i) inside
      fjt_pkg::PH_FIRST_KEY, fjt_pkg::PH_NEXT_KEY: begin
        if (!blank) begin
          if (text_byte_i == fjt_pkg::CH_QUOTE) begin
            nx = fjt_pkg::PH_IN_KEY;
          end else if (text_byte_i == fjt_pkg::CH_RBRACE &&
                       phase_i == fjt_pkg::PH_FIRST_KEY) begin
            kind = fjt_pkg::K_OBJEND;
            nx   = fjt_pkg::PH_WAIT_OPEN;
          end else begin
            err = fjt_pkg::E_NO_KEY_QUOTE;
          end
        end
      end
      fjt_pkg::PH_IN_KEY: begin
        if (text_byte_i == fjt_pkg::CH_QUOTE) begin
          kind = fjt_pkg::K_KEYEND;
          nx   = fjt_pkg::PH_AFTER_KEY;
        end else begin
          kind  = fjt_pkg::K_KEYBYTE;
          tbyte = text_byte_i;
        end
      end
      fjt_pkg::PH_AFTER_KEY: begin
        if (!blank) begin
          if (text_byte_i == fjt_pkg::CH_COLON) begin
            nx = fjt_pkg::PH_BEFORE_VAL;
          end else begin
            err = fjt_pkg::E_NO_COLON;
          end
        end
      end
      fjt_pkg::PH_BEFORE_VAL: begin
        if (!blank) begin
          if (text_byte_i == fjt_pkg::CH_QUOTE) begin
            nx = fjt_pkg::PH_IN_VAL;
          end else begin
            err = fjt_pkg::E_NO_VALUE_QUOTE;
          end
        end
      end
      fjt_pkg::PH_IN_VAL: begin
        if (text_byte_i == fjt_pkg::CH_QUOTE) begin
          kind = fjt_pkg::K_PAIREND;
          nx   = fjt_pkg::PH_AFTER_VAL;
        end else begin
          kind  = fjt_pkg::K_VALBYTE;
          tbyte = text_byte_i;
        end
      end
      fjt_pkg::PH_AFTER_VAL: begin
        if (text_byte_i == fjt_pkg::CH_COMMA) begin
          nx = fjt_pkg::PH_NEXT_KEY;
        end else if (text_byte_i == fjt_pkg::CH_RBRACE) begin
          kind = fjt_pkg::K_OBJEND;
          nx   = fjt_pkg::PH_WAIT_OPEN;
        end else if (blank) begin
          nx = fjt_pkg::PH_AFTER_VALWS;
        end else begin
          err = fjt_pkg::E_NO_COMMA;
        end
      end
      fjt_pkg::PH_AFTER_VALWS: begin
        if (!blank) begin
          if (text_byte_i == fjt_pkg::CH_RBRACE) begin
            kind = fjt_pkg::K_OBJEND;
            nx   = fjt_pkg::PH_WAIT_OPEN;
          end else begin
            err = fjt_pkg::E_NO_COMMA;
          end
        end
      end
      default: begin
        if (blank) begin
          nx = fjt_pkg::PH_WAIT_OPEN;
        end else if (text_byte_i == fjt_pkg::CH_LBRACE) begin
          nx = fjt_pkg::PH_FIRST_KEY;
        end else begin
          err = fjt_pkg::E_NO_BRACE;
        end
      end
    endcase

    // An object still open at the last byte turns into an error.
    if (err == fjt_pkg::E_NONE && end_of_text_i && kind != fjt_pkg::K_OBJEND) begin
      err = end_error(nx);
    end

    nx_final = nx;
    if (err != fjt_pkg::E_NONE) begin
      kind     = fjt_pkg::K_ERROR;
      tbyte    = 8'd0;
      nx_final = fjt_pkg::PH_WAIT_OPEN;
    end
    if (end_of_text_i) begin
      nx_final = fjt_pkg::PH_WAIT_OPEN;
    end
  end

  assign phase_nxt_o         = nx_final;
  assign result_o.token_kind = kind;
  assign result_o.token_byte = tbyte;
  assign result_o.error_code = err;

endmodule

### rtl/core/flat_json_object_tokenizer_unit.sv
// Top level of the flat object tokenizer: phase register and two-entry result buffer.
`timescale 1ns / 1ps
`include "flat_json_object_tokenizer_unit_defines.svh"

// Takes one byte of object text per beat and gives exactly one tagged result
// beat for it from the registered result buffer; with the result side
// unstalled it sustains one byte per clock. The parse phase lives in a single
// register that is updated as each byte is accepted, and each result lands in
// an output register backed by one skid entry, so in_stall rises only when
// both hold a result that the consumer has not taken.
module flat_json_object_tokenizer_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_token_kind,
  output logic [7:0] out_token_byte,
  output logic [2:0] out_error_code
);

  fjt_pkg::phase_t  phase_r;
  fjt_pkg::phase_t  phase_nxt;
  fjt_pkg::result_t step_result;
  fjt_pkg::result_t out_data_r;
  fjt_pkg::result_t skid_data_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             in_acc;
  logic             out_take;

  fjt_step u_step (
    .phase_i       (phase_r),
    .text_byte_i   (in_text_byte),
    .end_of_text_i (in_end_of_text),
    .phase_nxt_o   (phase_nxt),
    .result_o      (step_result)
  );

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fjt_pkg::PH_WAIT_OPEN;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (in_acc) begin
        out_data_r <= step_result;
      end
    end else if (in_acc) begin
      skid_data_r <= step_result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_token_kind = out_data_r.token_kind;
  assign out_token_byte = out_data_r.token_byte;
  assign out_error_code = out_data_r.error_code;

  `FJT_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `FJT_ASSERT_NEXT(a_end_resets_phase, clk, rst_n, in_acc && in_end_of_text,
                   phase_r == fjt_pkg::PH_WAIT_OPEN)
  `FJT_ASSERT_IMPL(a_error_has_code, clk, rst_n,
                   out_valid_r && out_token_kind == fjt_pkg::K_ERROR,
                   out_error_code != fjt_pkg::E_NONE && out_token_byte == 8'd0)
  `FJT_ASSERT_IMPL(a_code_only_on_error, clk, rst_n,
                   out_valid_r && out_token_kind != fjt_pkg::K_ERROR,
                   out_error_code == fjt_pkg::E_NONE)
  `FJT_ASSERT_NEXT(a_error_resets_phase, clk, rst_n,
                   in_acc && step_result.token_kind == fjt_pkg::K_ERROR,
                   phase_r == fjt_pkg::PH_WAIT_OPEN)

endmodule

### tb/flat_json_object_tokenizer_unit_test.sv
// Self-checking testbench for the flat object tokenizer: directed rows, then random object text.
`timescale 1ns / 1ps

module flat_json_object_tokenizer_unit_test;

  localparam int CycleLimit = 500000;
  localparam int RandomItems = 1000;
  localparam int BurstItems = 150;
  localparam int LongHold = 80;
  localparam int MaxReports = 50;

  typedef struct {
    logic [7:0]       text;
    logic             eot;
    logic             fixed;
    fjt_pkg::result_t want;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_text_byte;
  logic       in_end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_token_kind;
  logic [7:0] out_token_byte;
  logic [2:0] out_error_code;

  fjt_pkg::phase_t  token_phase = fjt_pkg::PH_WAIT_OPEN;
  fjt_pkg::result_t pending_tokens[$];
  stim_row_t        directed_rows[$];
  logic [8:0]       text_q[$];
  int               mismatch_count = 0;
  int               token_count = 0;
  int unsigned      cycle_count = 0;
  logic             burst_phase = 1'b0;

  always #10 clk = ~clk;

  flat_json_object_tokenizer_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_text_byte(in_text_byte),
    .in_end_of_text(in_end_of_text),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_token_kind(out_token_kind),
    .out_token_byte(out_token_byte),
    .out_error_code(out_error_code)
  );

  function automatic fjt_pkg::result_t tokenize_byte(input logic [7:0] c, input logic last);
    logic [2:0]       kind;
    logic [2:0]       code;
    logic [7:0]       tbyte;
    fjt_pkg::phase_t  nx;
    logic             blank;
    fjt_pkg::result_t r;
    kind = fjt_pkg::K_NONE;
    code = fjt_pkg::E_NONE;
    tbyte = 8'h00;
    nx = token_phase;
    blank = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    case (token_phase)
      fjt_pkg::PH_FIRST_KEY, fjt_pkg::PH_NEXT_KEY: begin
        if (!blank) begin
          if (c == fjt_pkg::CH_QUOTE) begin
            nx = fjt_pkg::PH_IN_KEY;
          end else if (c == fjt_pkg::CH_RBRACE && token_phase == fjt_pkg::PH_FIRST_KEY) begin
            kind = fjt_pkg::K_OBJEND;
            nx = fjt_pkg::PH_WAIT_OPEN;
          end else begin
            code = fjt_pkg::E_NO_KEY_QUOTE;
          end
        end
      end
      fjt_pkg::PH_IN_KEY: begin
        if (c == fjt_pkg::CH_QUOTE) begin
          kind = fjt_pkg::K_KEYEND;
          nx = fjt_pkg::PH_AFTER_KEY;
        end else begin
          kind = fjt_pkg::K_KEYBYTE;
          tbyte = c;
        end
      end
      fjt_pkg::PH_AFTER_KEY: begin
        if (!blank) begin
          if (c == fjt_pkg::CH_COLON) nx = fjt_pkg::PH_BEFORE_VAL;
          else code = fjt_pkg::E_NO_COLON;
        end
      end
      fjt_pkg::PH_BEFORE_VAL: begin
        if (!blank) begin
          if (c == fjt_pkg::CH_QUOTE) nx = fjt_pkg::PH_IN_VAL;
          else code = fjt_pkg::E_NO_VALUE_QUOTE;
        end
      end
      fjt_pkg::PH_IN_VAL: begin
        if (c == fjt_pkg::CH_QUOTE) begin
          kind = fjt_pkg::K_PAIREND;
          nx = fjt_pkg::PH_AFTER_VAL;
        end else begin
          kind = fjt_pkg::K_VALBYTE;
          tbyte = c;
        end
      end
      fjt_pkg::PH_AFTER_VAL: begin
        if (c == fjt_pkg::CH_COMMA) begin
          nx = fjt_pkg::PH_NEXT_KEY;
        end else if (c == fjt_pkg::CH_RBRACE) begin
          kind = fjt_pkg::K_OBJEND;
          nx = fjt_pkg::PH_WAIT_OPEN;
        end else if (blank) begin
          nx = fjt_pkg::PH_AFTER_VALWS;
        end else begin
          code = fjt_pkg::E_NO_COMMA;
        end
      end
      fjt_pkg::PH_AFTER_VALWS: begin
        if (!blank) begin
          if (c == fjt_pkg::CH_RBRACE) begin
            kind = fjt_pkg::K_OBJEND;
            nx = fjt_pkg::PH_WAIT_OPEN;
          end else begin
            code = fjt_pkg::E_NO_COMMA;
          end
        end
      end
      default: begin
        if (blank) nx = fjt_pkg::PH_WAIT_OPEN;
        else if (c == fjt_pkg::CH_LBRACE) nx = fjt_pkg::PH_FIRST_KEY;
        else code = fjt_pkg::E_NO_BRACE;
      end
    endcase
    if (code == fjt_pkg::E_NONE && last && kind != fjt_pkg::K_OBJEND) begin
      case (nx)
        fjt_pkg::PH_FIRST_KEY, fjt_pkg::PH_NEXT_KEY:    code = fjt_pkg::E_NO_KEY_QUOTE;
        fjt_pkg::PH_IN_KEY:                             code = fjt_pkg::E_OPEN_KEY;
        fjt_pkg::PH_AFTER_KEY:                          code = fjt_pkg::E_NO_COLON;
        fjt_pkg::PH_BEFORE_VAL:                         code = fjt_pkg::E_NO_VALUE_QUOTE;
        fjt_pkg::PH_IN_VAL:                             code = fjt_pkg::E_OPEN_VALUE;
        fjt_pkg::PH_AFTER_VAL, fjt_pkg::PH_AFTER_VALWS: code = fjt_pkg::E_NO_COMMA;
        default:                                        code = fjt_pkg::E_NO_BRACE;
      endcase
    end
    if (code != fjt_pkg::E_NONE) begin
      kind = fjt_pkg::K_ERROR;
      tbyte = 8'h00;
      nx = fjt_pkg::PH_WAIT_OPEN;
    end
    if (last) nx = fjt_pkg::PH_WAIT_OPEN;
    token_phase = nx;
    r.token_kind = kind;
    r.token_byte = tbyte;
    r.error_code = code;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want_v,
                                 input int unsigned got_v);
    if (mismatch_count < MaxReports) begin
      $display("token %0d: %s expected %0d, got %0d", token_count, what, want_v, got_v);
    end
    mismatch_count++;
  endtask

  task automatic add_text_row(input logic [7:0] text, input logic eot);
    stim_row_t r;
    r.text = text;
    r.eot = eot;
    r.fixed = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endtask

  task automatic add_checked_row(input logic [7:0] text, input logic eot,
                                 input logic [2:0] kind, input logic [7:0] tbyte,
                                 input logic [2:0] code);
    stim_row_t r;
    r.text = text;
    r.eot = eot;
    r.fixed = 1'b1;
    r.want.token_kind = kind;
    r.want.token_byte = tbyte;
    r.want.error_code = code;
    directed_rows.push_back(r);
  endtask

  task automatic send_beat(input logic [7:0] text, input logic eot, input logic fixed,
                           input fjt_pkg::result_t want, input bit no_gaps);
    int               pick;
    int               gap;
    fjt_pkg::result_t predicted;
    gap = 0;
    if (!no_gaps) begin
      pick = $urandom_range(0, 19);
      if (pick >= 19) gap = $urandom_range(10, 30);
      else if (pick >= 12) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= text;
    in_end_of_text <= eot;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = tokenize_byte(text, eot);
    pending_tokens.push_back(fixed ? want : predicted);
  endtask

  task automatic append_blanks(input int n);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      b = ($urandom_range(0, 5) == 5) ? 8'd32 : 8'($urandom_range(9, 13));
      text_q.push_back({1'b0, b});
    end
  endtask

  task automatic append_quoted();
    int         len;
    logic [7:0] b;
    len = ($urandom_range(0, 11) == 0) ? 12 : $urandom_range(0, 5);
    text_q.push_back({1'b0, fjt_pkg::CH_QUOTE});
    for (int k = 0; k < len; k++) begin
      do b = 8'($urandom_range(0, 255)); while (b == fjt_pkg::CH_QUOTE);
      text_q.push_back({1'b0, b});
    end
    text_q.push_back({1'b0, fjt_pkg::CH_QUOTE});
  endtask

  task automatic build_object();
    int pairs;
    int twist;
    int pick;
    int len;
    twist = $urandom_range(0, 7);
    pairs = $urandom_range(0, 3);
    if ($urandom_range(0, 2) == 0) append_blanks($urandom_range(1, 3));
    text_q.push_back({1'b0, fjt_pkg::CH_LBRACE});
    for (int p = 0; p < pairs; p++) begin
      if (p > 0) begin
        if (twist == 1) append_blanks(1);
        text_q.push_back({1'b0, fjt_pkg::CH_COMMA});
      end
      if ($urandom_range(0, 2) == 0) append_blanks($urandom_range(1, 2));
      append_quoted();
      if ($urandom_range(0, 2) == 0) append_blanks($urandom_range(1, 2));
      text_q.push_back({1'b0, fjt_pkg::CH_COLON});
      if ($urandom_range(0, 2) == 0) append_blanks($urandom_range(1, 2));
      append_quoted();
    end
    if (twist == 2 && pairs > 0) text_q.push_back({1'b0, fjt_pkg::CH_COMMA});
    if ($urandom_range(0, 2) == 0) append_blanks($urandom_range(1, 2));
    text_q.push_back({1'b0, fjt_pkg::CH_RBRACE});
    if ($urandom_range(0, 2) == 0) text_q[text_q.size() - 1][8] = 1'b1;
    pick = $urandom_range(0, 11);
    if (pick <= 1) begin
      text_q[$urandom_range(0, text_q.size() - 1)][7:0] = 8'($urandom_range(0, 255));
    end else if (pick == 2) begin
      len = $urandom_range(1, text_q.size());
      while (text_q.size() > len) void'(text_q.pop_back());
      text_q[text_q.size() - 1][8] = 1'b1;
    end else if (pick == 3) begin
      text_q[$urandom_range(0, text_q.size() - 1)][8] = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    fjt_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch("unexpected beat, kind", 0, out_token_kind);
      end else begin
        want = pending_tokens.pop_front();
        if (out_token_kind !== want.token_kind)
          report_mismatch("token_kind", want.token_kind, out_token_kind);
        if (out_token_byte !== want.token_byte)
          report_mismatch("token_byte", want.token_byte, out_token_byte);
        if (out_error_code !== want.error_code)
          report_mismatch("error_code", want.error_code, out_error_code);
      end
      token_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int hold;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (burst_phase && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold = LongHold;
      end else if ($urandom_range(0, 3) == 0) begin
        hold = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end else begin
        hold = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
        @(posedge clk);
    end
  end

  initial begin
    int sent;
    int n;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_text_byte <= 8'h00;
    in_end_of_text <= 1'b0;

    add_checked_row(8'h00, 1'b0, fjt_pkg::K_ERROR, 8'h00, fjt_pkg::E_NO_BRACE);
    add_checked_row(8'h20, 1'b0, fjt_pkg::K_NONE, 8'h00, fjt_pkg::E_NONE);
    add_text_row(fjt_pkg::CH_LBRACE, 1'b0);
    add_checked_row(fjt_pkg::CH_RBRACE, 1'b0, fjt_pkg::K_OBJEND, 8'h00, fjt_pkg::E_NONE);
    add_checked_row(8'h09, 1'b1, fjt_pkg::K_ERROR, 8'h00, fjt_pkg::E_NO_BRACE);
    add_text_row(fjt_pkg::CH_LBRACE, 1'b0);
    add_text_row(fjt_pkg::CH_QUOTE, 1'b0);
    add_checked_row(8'hFF, 1'b0, fjt_pkg::K_KEYBYTE, 8'hFF, fjt_pkg::E_NONE);
    add_checked_row(fjt_pkg::CH_QUOTE, 1'b0, fjt_pkg::K_KEYEND, 8'h00, fjt_pkg::E_NONE);
    add_text_row(8'h0D, 1'b0);
    add_text_row(fjt_pkg::CH_COLON, 1'b0);
    add_text_row(fjt_pkg::CH_QUOTE, 1'b0);
    add_checked_row(8'h00, 1'b0, fjt_pkg::K_VALBYTE, 8'h00, fjt_pkg::E_NONE);
    add_checked_row(fjt_pkg::CH_QUOTE, 1'b0, fjt_pkg::K_PAIREND, 8'h00, fjt_pkg::E_NONE);
    add_text_row(fjt_pkg::CH_COMMA, 1'b0);
    add_checked_row(fjt_pkg::CH_RBRACE, 1'b0, fjt_pkg::K_ERROR, 8'h00,
                    fjt_pkg::E_NO_KEY_QUOTE);
    add_text_row(fjt_pkg::CH_LBRACE, 1'b0);
    add_text_row(fjt_pkg::CH_QUOTE, 1'b0);
    add_text_row(fjt_pkg::CH_QUOTE, 1'b0);
    add_text_row(fjt_pkg::CH_COLON, 1'b0);
    add_text_row(fjt_pkg::CH_QUOTE, 1'b0);
    add_text_row(fjt_pkg::CH_QUOTE, 1'b0);
    add_text_row(8'h0A, 1'b0);
    add_checked_row(fjt_pkg::CH_COMMA, 1'b0, fjt_pkg::K_ERROR, 8'h00, fjt_pkg::E_NO_COMMA);
    add_text_row(fjt_pkg::CH_LBRACE, 1'b0);
    add_text_row(fjt_pkg::CH_QUOTE, 1'b0);
    add_checked_row(8'h41, 1'b1, fjt_pkg::K_ERROR, 8'h00, fjt_pkg::E_OPEN_KEY);
    add_text_row(fjt_pkg::CH_LBRACE, 1'b0);
    add_checked_row(fjt_pkg::CH_RBRACE, 1'b1, fjt_pkg::K_OBJEND, 8'h00, fjt_pkg::E_NONE);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].text, directed_rows[r].eot, directed_rows[r].fixed,
                directed_rows[r].want, 1'b0);
    end

    burst_phase <= 1'b1;
    sent = 0;
    while (sent < RandomItems) begin
      text_q.delete();
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
          text_q.push_back({($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0,
                            8'($urandom_range(0, 255))});
        end
      end else begin
        build_object();
      end
      foreach (text_q[k]) begin
        send_beat(text_q[k][7:0], text_q[k][8], 1'b0, '0, sent < BurstItems);
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
